// ----- rtl/pww_pkg.sv -----
// Shared types and constants for the proportional word wrap unit.
// Used by pww_ctrl, pww_datapath and proportional_word_wrap_unit.
package pww_pkg;

  localparam int WORD_CHARS_DEF = 32;

  localparam int POS_W      = 12;
  localparam int LW_W       = 10;
  localparam int SW_W       = 6;
  localparam int CW_W       = 6;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 10;

  localparam logic [POS_W-1:0] POS_MAX         = 12'd4095;
  localparam logic [LW_W-1:0]  LINE_WIDTH_RST  = 10'd239;
  localparam logic [SW_W-1:0]  SPACE_WIDTH_RST = 6'd6;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_WIDTH = 8'd1;

  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

  // what an accepted item does to the word store and the line
  typedef enum logic [2:0] {
    K_APPEND,
    K_DROP,
    K_SEP,
    K_SHIFT,
    K_BREAK,
    K_DBLNL,
    K_FLUSH
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRD,
    S_WLD,
    S_NL1,
    S_NL2,
    S_FIN
  } state_t;

  typedef struct packed {
    logic accept;     // take the input item, update line state
    logic rd;         // read next word byte from the store
    logic word_last;  // byte being read is the final result
    logic load_word;  // move read byte into the output register
    logic load_nl;    // put a newline into the output register
    logic nl_last;    // that newline is the final result
    logic wr_fin;     // deferred write at the word head
    logic fin_space;  // deferred write is a space, else the held byte
  } cmd_t;

  typedef struct packed {
    kind_t kind;      // decode of the item at the input
    logic  emit_empty;
    logic  emit_one;
    logic  slot_free; // output register can take a byte
  } stat_t;

endpackage

// ----- rtl/pww_ctrl.sv -----
// Controller for the word wrap unit: sequences word emission, newlines
// and the deferred store write. Depends on pww_pkg.
module pww_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pww_pkg::stat_t st,
  output pww_pkg::cmd_t  cmd
);
  import pww_pkg::*;

  state_t state, state_next;
  kind_t  kind_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      kind_q <= K_APPEND;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) kind_q <= st.kind;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (st.kind)
            K_SEP, K_BREAK, K_FLUSH: state_next = S_WRD;
            K_SHIFT, K_DBLNL:        state_next = S_NL1;
            default:                 state_next = S_IDLE;
          endcase
        end
      end
      S_WRD: begin
        if (st.emit_empty) state_next = (kind_q == K_SEP) ? S_FIN : S_NL1;
        else state_next = S_WLD;
      end
      S_WLD: begin
        if (st.slot_free) state_next = S_WRD;
      end
      S_NL1: begin
        if (st.slot_free) begin
          if (kind_q == K_DBLNL) state_next = S_NL2;
          else if (kind_q == K_BREAK) state_next = S_FIN;
          else state_next = S_IDLE;
        end
      end
      S_NL2: begin
        if (st.slot_free) state_next = S_IDLE;
      end
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd           = '0;
    cmd.accept    = (state == S_IDLE) && in_valid;
    cmd.rd        = (state == S_WRD) && !st.emit_empty;
    cmd.word_last = st.emit_one && (kind_q == K_SEP);
    cmd.load_word = (state == S_WLD) && st.slot_free;
    cmd.load_nl   = (state == S_NL1 || state == S_NL2) && st.slot_free;
    cmd.nl_last   = (state == S_NL2) || (kind_q != K_DBLNL);
    cmd.wr_fin    = (state == S_FIN);
    cmd.fin_space = (kind_q == K_SEP);
  end

endmodule

// ----- rtl/pww_datapath.sv -----
// Datapath for the word wrap unit: word store ring, line position,
// configuration registers and output register. Depends on pww_pkg.
module pww_datapath #(
  parameter int WORD_CHARS = pww_pkg::WORD_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pww_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pww_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_action,
  input  logic [pww_pkg::CH_W-1:0]        in_char,
  input  logic [pww_pkg::CW_W-1:0]        in_width,
  input  pww_pkg::cmd_t                   cmd,
  output pww_pkg::stat_t                  st,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pww_pkg::CH_W-1:0]        out_char,
  output logic                            out_last,
  output logic                            out_ovf
);
  import pww_pkg::*;

  localparam int PTR_W = $clog2(WORD_CHARS);
  localparam int LEN_W = $clog2(WORD_CHARS + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WORD_CHARS - 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(WORD_CHARS);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
  localparam logic [LEN_W:0]   W_T      = (LEN_W + 1)'(WORD_CHARS);

  logic [CH_W-1:0]  mem [WORD_CHARS];
  logic [CH_W-1:0]  rd_data;
  logic             rd_last;

  logic [LW_W-1:0]  lw;
  logic [SW_W-1:0]  sw;
  logic [PTR_W-1:0] head;
  logic [LEN_W-1:0] len;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] start;
  logic             pending;
  logic             overflow;
  logic [CH_W-1:0]  char_q;
  logic [PTR_W-1:0] emit_ptr;
  logic [LEN_W-1:0] emit_left;

  logic [POS_W:0]   np_sum, sp_sum, sub, diff, tsum, tmod;
  logic [POS_W-1:0] np, sep_pos, shift_pos;
  logic [PTR_W-1:0] tail, head_inc, emit_inc;
  logic             is_sep, wrap;
  kind_t            kind;

  logic             mem_we;
  logic [PTR_W-1:0] mem_wa;
  logic [CH_W-1:0]  mem_wd;

  // position arithmetic, saturating at POS_MAX
  assign np_sum  = {1'b0, pos} + {{(POS_W + 1 - CW_W){1'b0}}, in_width};
  assign np      = (np_sum > {1'b0, POS_MAX}) ? POS_MAX : np_sum[POS_W-1:0];
  assign sp_sum  = {1'b0, pos} + {{(POS_W + 1 - SW_W){1'b0}}, sw};
  assign sep_pos = (sp_sum > {1'b0, POS_MAX}) ? POS_MAX : sp_sum[POS_W-1:0];

  // drop the leading space and the text before the word
  assign sub       = {1'b0, start} + {{(POS_W + 1 - SW_W){1'b0}}, sw};
  assign diff      = {1'b0, np} - sub;
  assign shift_pos = ({1'b0, np} >= sub) ? diff[POS_W-1:0] : '0;

  // ring position after the last buffered byte
  assign tsum = {{(POS_W + 1 - PTR_W){1'b0}}, head} + {{(POS_W + 1 - LEN_W){1'b0}}, len};
  assign tmod = (tsum >= {{(POS_W - LEN_W){1'b0}}, W_T}) ?
                (tsum - {{(POS_W - LEN_W){1'b0}}, W_T}) : tsum;
  assign tail = tmod[PTR_W-1:0];

  assign head_inc = (head == PTR_LAST) ? '0 : head + 1'b1;
  assign emit_inc = (emit_ptr == PTR_LAST) ? '0 : emit_ptr + 1'b1;

  assign is_sep = (in_char == CH_SPACE) || (in_char == CH_TAB) || (in_char == CH_NL);
  assign wrap   = (np >= {{(POS_W - LW_W){1'b0}}, lw});

  always_comb begin
    if (in_action) kind = K_FLUSH;
    else if (pending && in_char == CH_NL) kind = K_DBLNL;
    else if (is_sep) kind = K_SEP;
    else if (wrap) kind = (start != '0) ? K_SHIFT : K_BREAK;
    else if (len >= LEN_FULL) kind = K_DROP;
    else kind = K_APPEND;
  end

  assign st.kind       = kind;
  assign st.emit_empty = (emit_left == '0);
  assign st.emit_one   = (emit_left == LEN_ONE);
  assign st.slot_free  = !out_valid || out_ready;

  // appends go to the tail at accept; the word head is rewritten after emission
  assign mem_we = cmd.wr_fin || (cmd.accept && (kind == K_SHIFT || kind == K_APPEND));
  assign mem_wa = cmd.wr_fin ? head : tail;
  assign mem_wd = cmd.wr_fin ? (cmd.fin_space ? CH_SPACE : char_q) : in_char;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd) rd_data <= mem[emit_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw <= LINE_WIDTH_RST;
      sw <= SPACE_WIDTH_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_LINE_WIDTH) lw <= cfg_data[LW_W-1:0];
      else if (cfg_index == REG_SPACE_WIDTH) sw <= cfg_data[SW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      len       <= '0;
      pos       <= '0;
      start     <= '0;
      pending   <= 1'b0;
      overflow  <= 1'b0;
      emit_ptr  <= '0;
      emit_left <= '0;
      rd_last   <= 1'b0;
    end else if (cmd.accept) begin
      pending   <= (kind == K_SEP) && (in_char == CH_NL);
      emit_ptr  <= head;
      emit_left <= len;
      case (kind)
        K_FLUSH, K_DBLNL: begin
          len   <= '0;
          pos   <= '0;
          start <= '0;
        end
        K_SEP: begin
          start <= pos;
          len   <= LEN_ONE;
          pos   <= sep_pos;
        end
        K_SHIFT: begin
          pos   <= shift_pos;
          start <= '0;
          if (len != '0) head <= head_inc;
          else len <= LEN_ONE;
        end
        K_BREAK: begin
          start <= '0;
          pos   <= {{(POS_W - CW_W){1'b0}}, in_width};
          len   <= LEN_ONE;
        end
        K_DROP:   overflow <= 1'b1;
        K_APPEND: begin
          pos <= np;
          len <= len + 1'b1;
        end
        default: ;
      endcase
    end else if (cmd.rd) begin
      emit_ptr  <= emit_inc;
      emit_left <= emit_left - 1'b1;
      rd_last   <= cmd.word_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) char_q <= in_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_word || cmd.load_nl) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // flag is sampled at load so later items cannot change a waiting byte
  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      out_char <= rd_data;
      out_last <= rd_last;
      out_ovf  <= overflow;
    end else if (cmd.load_nl) begin
      out_char <= CH_NL;
      out_last <= cmd.nl_last;
      out_ovf  <= overflow;
    end
  end

endmodule

// ----- rtl/proportional_word_wrap_unit.sv -----
// Greedy word wrap for a proportional font, one byte per input transfer.
// A buffered byte is sent by a store read, then an output load that waits
// for a free output register; the controller then sees the word done, sends
// any newlines and, where needed, does the head rewrite. The input is not
// ready again until emission ends; a byte that is only buffered or dropped
// does not stall it.
// Reset: synchronous, clears positions, length and flags.
module proportional_word_wrap_unit #(
  parameter int WORD_CHARS = pww_pkg::WORD_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pww_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pww_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // char_code[7:0], char_width[13:8]
  input  logic                            s_axis_tuser,  // action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // out_char[7:0]
  output logic                            m_axis_tlast,
  output logic                            m_axis_tuser   // word_overflow
);
  import pww_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  pww_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  pww_datapath #(
    .WORD_CHARS (WORD_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_action (s_axis_tuser),
    .in_char   (s_axis_tdata[7:0]),
    .in_width  (s_axis_tdata[13:8]),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_ovf   (m_axis_tuser)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_word || cmd.load_nl) |-> st.slot_free)
    else $error("output register loaded while occupied");

  a_rd_gap: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> !cmd.rd)
    else $error("store read not followed by output load");

  a_quiet_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (st.kind == K_APPEND || st.kind == K_DROP))
    |=> s_axis_tready)
    else $error("buffered byte stalled the input");

  a_flush_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && st.kind == K_FLUSH) |=> !s_axis_tready)
    else $error("flush did not start emission");

endmodule

// ----- bench/pww_wrap_checker.sv -----
// Scoreboard for proportional_word_wrap_unit: follows config transfers, predicts
// the wrapped byte stream of every input transfer and compares output transfers.
// Depends on pww_pkg for widths, register indexes and character codes.
`timescale 1ns / 100ps

module pww_wrap_checker #(
  parameter int WORD_CHARS = pww_pkg::WORD_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pww_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pww_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // char_code[7:0], char_width[13:8]
  input  logic                           s_axis_tuser,  // action
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [7:0]                     m_axis_tdata,  // out_char[7:0]
  input  logic                           m_axis_tlast,
  input  logic                           m_axis_tuser,  // word_overflow
  output int                             mismatches,
  output int                             pending
);
  import pww_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic            ovf;
  } wrap_byte_t;

  wrap_byte_t      wrap_q[$];
  wrap_byte_t      head;
  logic [CH_W-1:0] released[$];
  logic [CH_W-1:0] word_buf[WORD_CHARS];
  int unsigned     word_len, line_pos, word_start;
  logic            nl_pending, dropped;
  logic [LW_W-1:0] line_width;
  logic [SW_W-1:0] space_width;
  int              n_pushed, n_popped, n_bytes, n_new;

  assign pending = n_pushed - n_popped;

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("mismatch on %s at byte %0d: got %0h, expected %0h", field, n_bytes, got, want);
    mismatches++;
  endtask

  function automatic int unsigned sat_pos(int unsigned a, int unsigned b);
    return (a + b > POS_MAX) ? POS_MAX : a + b;
  endfunction

  function automatic void release_word();
    for (int i = 0; i < word_len; i++) released.push_back(word_buf[i]);
  endfunction

  // One input transfer: update the line state and queue the bytes it releases.
  function automatic int wrap_item(logic flush, logic [CH_W-1:0] code, logic [CW_W-1:0] cw);
    logic [CH_W-1:0] c;
    int unsigned     np, sub;
    logic            done;
    wrap_byte_t      e;
    released.delete();
    c = code;
    done = 1'b0;
    if (flush) begin
      release_word();
      released.push_back(CH_NL);
      word_len = 0;
      line_pos = 0;
      word_start = 0;
      nl_pending = 1'b0;
    end else begin
      if (nl_pending) begin
        nl_pending = 1'b0;
        if (c == CH_NL) begin
          // paragraph break
          released.push_back(CH_NL);
          released.push_back(CH_NL);
          word_len = 0;
          line_pos = 0;
          word_start = 0;
          done = 1'b1;
        end
      end
      if (!done) begin
        if (c == CH_TAB) c = CH_SPACE;
        if (c == CH_SPACE || c == CH_NL) begin
          release_word();
          word_start = line_pos;
          word_buf[0] = CH_SPACE;
          word_len = 1;
          line_pos = sat_pos(line_pos, space_width);
          if (c == CH_NL) nl_pending = 1'b1;
        end else begin
          np = sat_pos(line_pos, cw);
          if (np >= line_width) begin
            if (word_start != 0) begin
              // word moves down: drop its leading space
              sub = word_start + space_width;
              line_pos = (np >= sub) ? np - sub : 0;
              if (word_len > 0) begin
                for (int i = 0; i + 1 < word_len; i++) word_buf[i] = word_buf[i + 1];
                word_len--;
              end
              released.push_back(CH_NL);
              if (word_len < WORD_CHARS) begin
                word_buf[word_len] = c;
                word_len++;
              end
              word_start = 0;
            end else begin
              // word already starts the line: break it here
              release_word();
              released.push_back(CH_NL);
              word_start = 0;
              line_pos = cw;
              word_buf[0] = c;
              word_len = 1;
            end
          end else if (word_len >= WORD_CHARS) begin
            dropped = 1'b1;
          end else begin
            line_pos = np;
            word_buf[word_len] = c;
            word_len++;
          end
        end
      end
    end
    foreach (released[k]) begin
      e.ch = released[k];
      e.last = (k == released.size() - 1);
      e.ovf = dropped;
      wrap_q.push_back(e);
    end
    return released.size();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      wrap_q.delete();
      word_len = 0;
      line_pos = 0;
      word_start = 0;
      nl_pending = 1'b0;
      dropped = 1'b0;
      line_width = LINE_WIDTH_RST;
      space_width = SPACE_WIDTH_RST;
      n_bytes = 0;
      mismatches = 0;
      n_pushed <= 0;
      n_popped <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (wrap_q.size() == 0) begin
          report_mismatch("unexpected byte", m_axis_tdata, 0);
        end else begin
          head = wrap_q.pop_front();
          if (m_axis_tdata !== head.ch) report_mismatch("out_char", m_axis_tdata, head.ch);
          if (m_axis_tlast !== head.last) report_mismatch("last", m_axis_tlast, head.last);
          if (m_axis_tuser !== head.ovf) report_mismatch("word_overflow", m_axis_tuser, head.ovf);
          n_popped <= n_popped + 1;
        end
        n_bytes++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LINE_WIDTH:  line_width = cfg_data[LW_W-1:0];
          REG_SPACE_WIDTH: space_width = cfg_data[SW_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_new = wrap_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[13:8]);
        n_pushed <= n_pushed + n_new;
      end
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for proportional_word_wrap_unit: drives text and config
// transfers with random idling and gives the verdict.
// Depends on pww_pkg and pww_wrap_checker.
`timescale 1ns / 100ps

module tb_top;
  import pww_pkg::*;

  localparam int WORD_CHARS    = WORD_CHARS_DEF;
  localparam int IDLE_PCT      = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int STUCK_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 22;
  localparam int N_PHASES      = 8;
  localparam int STEADY_PHASE  = 2;
  localparam int SAT_PHASE     = 2;
  localparam int SAT_RUN       = 66;
  localparam int WIDE_LINE     = 1000;

  logic                  clk, rst;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [15:0]           s_axis_tdata;
  logic                  m_axis_tvalid, m_axis_tready, m_axis_tlast, m_axis_tuser;
  logic [7:0]            m_axis_tdata;
  int                    mismatches, pending, stuck_cycles, items_sent;
  logic                  steady;

  // per phase: line width, space width, largest glyph width in words
  int unsigned lw_list[N_PHASES]   = '{239, 16, 1023, 0, 40, 1023, 239, 15};
  int unsigned sw_list[N_PHASES]   = '{6, 0, 63, 6, 63, 0, 6, 1};
  int unsigned wmax_list[N_PHASES] = '{20, 8, 63, 10, 12, 3, 30, 5};

  proportional_word_wrap_unit #(.WORD_CHARS(WORD_CHARS)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
  );

  pww_wrap_checker #(.WORD_CHARS(WORD_CHARS)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .mismatches(mismatches), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog: input and config transfers count as progress, output transfers
  // only while a byte is still expected
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready && pending != 0) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send(logic flush, logic [CH_W-1:0] code, logic [CW_W-1:0] cw);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= flush;
    s_axis_tdata <= {2'b00, cw, code};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // hold off input until every predicted byte is out, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_widths(int unsigned lw, int unsigned sw);
    write_reg(REG_LINE_WIDTH, CFG_DATA_W'(lw));
    // bits above the space width field are don't-care
    write_reg(REG_SPACE_WIDTH, {(CFG_DATA_W-SW_W)'($urandom), SW_W'(sw)});
    if ($urandom_range(1))
      write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_SPACE_WIDTH + 1)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(int unsigned len, int unsigned wmax);
    repeat (len) send(1'b0, CH_W'($urandom_range(8'h7E, 8'h21)), CW_W'($urandom_range(wmax)));
  endtask

  task automatic send_gap();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) begin
      send(1'b0, CH_SPACE, CW_W'($urandom));
    end else if (r < 8) begin
      send(1'b0, CH_TAB, CW_W'($urandom));
    end else if (r < 9) begin
      send(1'b0, CH_NL, CW_W'($urandom));
    end else begin
      send(1'b0, CH_NL, CW_W'($urandom));
      send(1'b0, CH_NL, CW_W'($urandom));
    end
  endtask

  task automatic send_text(int unsigned n_items, int unsigned wmax);
    int unsigned stop_at, r;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_word($urandom_range(12, 1), wmax);
        send_gap();
      end else if (r < 78) begin
        send_word($urandom_range(WORD_CHARS + 8, WORD_CHARS - 2), 2);
        send_gap();
      end else if (r < 84) begin
        send(1'b1, CH_W'($urandom), CW_W'($urandom));
      end else if (r < 92) begin
        send(1'b0, CH_W'($urandom), CW_W'($urandom));
      end else begin
        // lone newline followed by a plain byte
        send(1'b0, CH_NL, CW_W'($urandom));
        send(1'b0, CH_W'($urandom_range(8'h7E, 8'h21)), CW_W'($urandom_range(wmax)));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    steady = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    items_sent = 0;
    lw_list[6] = $urandom_range(1023, 16);
    sw_list[6] = $urandom_range(63);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed text at the reset widths
    send(1'b1, 8'hFF, 6'h3F);          // flush with nothing buffered
    send(1'b0, 8'h00, 6'h00);
    send(1'b0, 8'hFF, 6'h3F);
    send(1'b0, CH_SPACE, 6'h00);
    send(1'b0, CH_TAB, 6'h3F);
    send(1'b0, 8'h41, 6'h3F);
    send(1'b0, 8'h42, 6'h3F);
    send(1'b0, 8'h43, 6'h3F);          // wraps, leading space removed
    send(1'b0, 8'h44, 6'h3F);          // word at line start is broken
    send(1'b0, CH_NL, 6'h00);
    send(1'b0, CH_NL, 6'h00);          // paragraph break
    send(1'b0, CH_NL, 6'h00);
    send(1'b0, 8'h78, 6'h0A);          // clears the pending newline
    send(1'b0, CH_TAB, 6'h00);
    send(1'b0, CH_NL, 6'h05);
    send(1'b0, CH_SPACE, 6'h00);
    send(1'b1, 8'h00, 6'h00);
    repeat (6) send(1'b0, 8'h57, 6'h3F);
    send(1'b1, 8'h00, 6'h00);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      set_widths(lw_list[p], sw_list[p]);
      steady = (p == STEADY_PHASE);
      if (lw_list[p] >= WIDE_LINE) begin
        // fill the word store past its end without wrapping
        send_word(WORD_CHARS + 4, 2);
        send_gap();
      end
      if (p == SAT_PHASE) begin
        // separators alone push the position to saturation
        repeat (SAT_RUN) send(1'b0, CH_SPACE, CW_W'($urandom));
        send_word(3, wmax_list[p]);
      end
      send_text(PHASE_ITEMS, wmax_list[p]);
      drain();
    end
    steady = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
